### hdl/pilu_pkg.sv
// Shared types and constants for the packed index lookup unit.
package pilu_pkg;

    localparam int PosWidth    = 13;   // entry positions, search bounds
    localparam int BitPosWidth = 21;   // stream bit address
    localparam int KeyWidth    = 31;
    localparam int DataWidth   = 32;
    localparam int CfgWidth    = 32;
    localparam int OffsetLimit = 32;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_FIND  = 2'd1,
        OP_RANGE = 2'd2,
        OP_KEY   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_META_SHIFT   = 3'd0,
        REG_OFFSET_WIDTH = 3'd1,
        REG_KEY_WIDTH    = 3'd2,
        REG_JUMP_WIDTH   = 3'd3,
        REG_ENTRY_COUNT  = 3'd4,
        REG_TOTAL_LENGTH = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_OFF1,
        ST_OFF2,
        ST_KEY_RD,
        ST_WAIT_A,
        ST_WAIT_B,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        FK_PROBE,
        FK_CHECK,
        FK_OFF1,
        FK_OFF2,
        FK_KEY
    } fetch_kind_t;

    // record layout as seen by the field fetch pipeline
    typedef struct packed {
        logic [5:0] meta_shift;
        logic [5:0] offset_width;   // already limited to 32
        logic [4:0] key_width;
        logic [6:0] step;           // offset + key + jump widths
    } layout_t;

endpackage

### hdl/pilu_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
module pilu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### hdl/pilu_fetch.sv
// Field fetch pipeline: record position to bit address, word reads, field extract.
module pilu_fetch #(
    parameter int INDEX_WORDS = 1024
) (
    input  logic                                   clk,
    input  logic                                   req,
    input  logic [pilu_pkg::PosWidth-1:0]          req_pos,
    input  logic                                   req_key,   // 1 key field, 0 offset
    input  pilu_pkg::layout_t                      layout,
    output logic [$clog2(INDEX_WORDS)-1:0]         raddr_a,
    output logic [$clog2(INDEX_WORDS)-1:0]         raddr_b,
    input  logic [63:0]                            rdata_a,
    input  logic [63:0]                            rdata_b,
    output logic [pilu_pkg::DataWidth-1:0]         field
);

    localparam int AW  = $clog2(INDEX_WORDS);
    localparam int BPW = pilu_pkg::BitPosWidth;

    // stage 1: stream bit address
    logic [BPW-1:0] bitpos_reg, bitpos_next;
    logic [5:0]     len_reg, len_next;
    // stage 2: word reads in flight
    logic [5:0]     sh_reg;
    logic [5:0]     len2_reg;
    logic           zero_a_reg, zero_b_reg;
    logic [31:0]    word_a, word_b;
    logic [127:0]   pair;
    logic [127:0]   shifted;
    logic [32:0]    mask;

    always_comb
    begin
        bitpos_next = BPW'(layout.meta_shift)
                    + (req_key ? BPW'(layout.offset_width) : BPW'(0))
                    + BPW'(req_pos) * BPW'(layout.step);
        len_next    = req_key ? {1'b0, layout.key_width} : layout.offset_width;
    end

    always_ff @(posedge clk)
    begin
        if (req)
        begin
            bitpos_reg <= bitpos_next;
            len_reg    <= len_next;
        end
    end

    always_comb
    begin
        word_a  = 32'(bitpos_reg >> 6);
        word_b  = word_a + 32'd1;
        raddr_a = word_a[AW-1:0];
        raddr_b = word_b[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        sh_reg     <= bitpos_reg[5:0];
        len2_reg   <= len_reg;
        zero_a_reg <= (word_a >= 32'(INDEX_WORDS));
        zero_b_reg <= (word_b >= 32'(INDEX_WORDS));
    end

    // words past the store read as zero
    always_comb
    begin
        pair    = {zero_b_reg ? 64'd0 : rdata_b, zero_a_reg ? 64'd0 : rdata_a};
        shifted = pair >> sh_reg;
        mask    = (33'd1 << len2_reg) - 33'd1;
        field   = shifted[31:0] & mask[31:0];
    end

endmodule

### hdl/packed_index_lookup_unit.sv
// Top level: bit-packed index store with load, lower-bound search, range and key reads.
// From the accepting edge to done: load goes straight to done; key read does one store fetch;
// data range one per offset read (none for record 0's offset or the last record's end); search
// one per probe, up to the bit length of the range size, and a key check. Store fetch: bit address,
// word read, field extract. One item at a time, busy high through done; the next transfer
// is taken in the cycle after done at the earliest. Results cannot be stalled. Reset: see below.
module packed_index_lookup_unit #(
    parameter int INDEX_WORDS = 1024,
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         op,
    input  logic [9:0]                         word_index,
    input  logic [63:0]                        word_value,
    input  logic [30:0]                        search_key,
    input  logic [12:0]                        begin_pos,
    input  logic [12:0]                        end_pos,
    input  logic [11:0]                        position,
    // result channel
    output logic                               done,
    output logic                               found,
    output logic [12:0]                        found_pos,
    output logic [31:0]                        data_offset,
    output logic [31:0]                        data_length,
    output logic [30:0]                        key_value,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [2:0]                         cfg_index,
    input  logic [31:0]                        cfg_data
);

    // Reset clears configuration and control; the store is not cleared.

    localparam int AW = $clog2(INDEX_WORDS);
    localparam int PW = pilu_pkg::PosWidth;

    // configuration registers
    logic [5:0]  meta_shift_reg;
    logic [5:0]  offset_width_reg;
    logic [4:0]  key_width_reg;
    logic [2:0]  jump_width_reg;
    logic [12:0] entry_count_reg;
    logic [31:0] total_length_reg;

    pilu_pkg::state_t      state_reg, state_next;
    pilu_pkg::fetch_kind_t kind_reg, kind_next;

    // item context
    logic [PW-1:0] lo_reg, lo_next;
    logic [PW-1:0] n_reg, n_next;
    logic [PW-1:0] epos_reg, epos_next;
    logic [30:0]   skey_reg, skey_next;
    logic [11:0]   pos_reg, pos_next;

    // result registers
    logic          found_reg, found_next;
    logic [12:0]   found_pos_reg, found_pos_next;
    logic [31:0]   data_offset_reg, data_offset_next;
    logic [31:0]   data_length_reg, data_length_next;
    logic [30:0]   key_value_reg, key_value_next;

    logic          accept;
    logic [PW-1:0] half, mid;
    logic [PW-1:0] bclamp, eclamp;
    logic [PW-1:0] pos_plus1;
    logic          last_entry;
    logic [5:0]    ow_eff;

    logic          fetch_req;
    logic [PW-1:0] fetch_pos;
    logic          fetch_key;

    pilu_pkg::layout_t layout;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     raddr_a, raddr_b;
    logic [63:0]       rdata_a, rdata_b;
    logic [31:0]       field;

    assign accept = start && (state_reg == pilu_pkg::ST_IDLE);

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_shift_reg   <= '0;
            offset_width_reg <= '0;
            key_width_reg    <= '0;
            jump_width_reg   <= '0;
            entry_count_reg  <= '0;
            total_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pilu_pkg::REG_META_SHIFT:   meta_shift_reg   <= cfg_data[5:0];
                pilu_pkg::REG_OFFSET_WIDTH: offset_width_reg <= cfg_data[5:0];
                pilu_pkg::REG_KEY_WIDTH:    key_width_reg    <= cfg_data[4:0];
                pilu_pkg::REG_JUMP_WIDTH:   jump_width_reg   <= cfg_data[2:0];
                pilu_pkg::REG_ENTRY_COUNT:  entry_count_reg  <= cfg_data[12:0];
                pilu_pkg::REG_TOTAL_LENGTH: total_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // offsets wider than 32 bits are read as 32
    assign ow_eff = (offset_width_reg > 6'(pilu_pkg::OffsetLimit))
                  ? 6'(pilu_pkg::OffsetLimit) : offset_width_reg;

    always_comb
    begin
        layout.meta_shift   = meta_shift_reg;
        layout.offset_width = ow_eff;
        layout.key_width    = key_width_reg;
        layout.step         = 7'(ow_eff) + 7'(key_width_reg) + 7'(jump_width_reg);
    end

    // ---------------- index store ----------------
    // Loads happen at the accepting edge; reads come only from later items,
    // so no read can overlap a write to the same word.
    assign ram_we    = accept && (op == pilu_pkg::OP_LOAD)
                    && (32'(word_index) < 32'(INDEX_WORDS));
    assign ram_waddr = AW'(word_index);

    pilu_ram #(
        .WIDTH (64),
        .DEPTH (INDEX_WORDS)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (word_value),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // field fetch: request in the issuing state, field valid in ST_WAIT_B after ST_WAIT_A
    pilu_fetch #(
        .INDEX_WORDS (INDEX_WORDS)
    ) u_fetch (
        .clk     (clk),
        .req     (fetch_req),
        .req_pos (fetch_pos),
        .req_key (fetch_key),
        .layout  (layout),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .field   (field)
    );

    // ---------------- search helpers ----------------
    assign half       = n_reg >> 1;
    assign mid        = lo_reg + half;
    assign pos_plus1  = PW'(pos_reg) + PW'(1);
    assign last_entry = (pos_plus1 == entry_count_reg);

    // clamp search bounds to the table size
    always_comb
    begin
        bclamp = (32'(begin_pos) > 32'(MAX_ENTRIES)) ? PW'(MAX_ENTRIES) : begin_pos;
        eclamp = (32'(end_pos) > 32'(MAX_ENTRIES)) ? PW'(MAX_ENTRIES) : end_pos;
    end

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pilu_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op)
                        pilu_pkg::OP_LOAD:  state_next = pilu_pkg::ST_DONE;
                        pilu_pkg::OP_FIND:  state_next = pilu_pkg::ST_PROBE;
                        pilu_pkg::OP_RANGE: state_next = pilu_pkg::ST_OFF1;
                        pilu_pkg::OP_KEY:   state_next = pilu_pkg::ST_KEY_RD;
                        default:            state_next = pilu_pkg::ST_IDLE;
                    endcase
                end
            end
            pilu_pkg::ST_PROBE:
            begin
                // range exhausted and lower bound at the end: nothing to check
                if (n_reg == '0 && lo_reg >= epos_reg)
                    state_next = pilu_pkg::ST_DONE;
                else
                    state_next = pilu_pkg::ST_WAIT_A;
            end
            pilu_pkg::ST_OFF1:
            begin
                if (pos_reg != '0)
                    state_next = pilu_pkg::ST_WAIT_A;
                else
                    state_next = pilu_pkg::ST_OFF2;
            end
            pilu_pkg::ST_OFF2:
            begin
                if (last_entry)
                    state_next = pilu_pkg::ST_DONE;
                else
                    state_next = pilu_pkg::ST_WAIT_A;
            end
            pilu_pkg::ST_KEY_RD: state_next = pilu_pkg::ST_WAIT_A;
            pilu_pkg::ST_WAIT_A: state_next = pilu_pkg::ST_WAIT_B;
            pilu_pkg::ST_WAIT_B:
            begin
                unique case (kind_reg)
                    pilu_pkg::FK_PROBE: state_next = pilu_pkg::ST_PROBE;
                    pilu_pkg::FK_OFF1:  state_next = pilu_pkg::ST_OFF2;
                    default:            state_next = pilu_pkg::ST_DONE;
                endcase
            end
            pilu_pkg::ST_DONE:   state_next = pilu_pkg::ST_IDLE;
            default:             state_next = pilu_pkg::ST_IDLE;
        endcase
    end

    // fetch requests and handshake outputs
    always_comb
    begin
        fetch_req = 1'b0;
        fetch_pos = lo_reg;
        fetch_key = 1'b1;
        kind_next = kind_reg;
        busy      = (state_reg != pilu_pkg::ST_IDLE);
        done      = (state_reg == pilu_pkg::ST_DONE);
        unique case (state_reg)
            pilu_pkg::ST_PROBE:
            begin
                if (n_reg != '0)
                begin
                    fetch_req = 1'b1;
                    fetch_pos = mid;
                    kind_next = pilu_pkg::FK_PROBE;
                end
                else if (lo_reg < epos_reg)
                begin
                    // exact-match check on the lower bound
                    fetch_req = 1'b1;
                    fetch_pos = lo_reg;
                    kind_next = pilu_pkg::FK_CHECK;
                end
            end
            pilu_pkg::ST_OFF1:
            begin
                fetch_req = (pos_reg != '0);
                fetch_pos = PW'(pos_reg);
                fetch_key = 1'b0;
                kind_next = pilu_pkg::FK_OFF1;
            end
            pilu_pkg::ST_OFF2:
            begin
                // next record's offset is this record's end
                fetch_req = !last_entry;
                fetch_pos = pos_plus1;
                fetch_key = 1'b0;
                kind_next = pilu_pkg::FK_OFF2;
            end
            pilu_pkg::ST_KEY_RD:
            begin
                fetch_req = 1'b1;
                fetch_pos = PW'(pos_reg);
                kind_next = pilu_pkg::FK_KEY;
            end
            default: ;
        endcase
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        lo_next          = lo_reg;
        n_next           = n_reg;
        epos_next        = epos_reg;
        skey_next        = skey_reg;
        pos_next         = pos_reg;
        found_next       = found_reg;
        found_pos_next   = found_pos_reg;
        data_offset_next = data_offset_reg;
        data_length_next = data_length_reg;
        key_value_next   = key_value_reg;

        if (accept)
        begin
            // fields that do not belong to the op stay zero
            found_next       = 1'b0;
            found_pos_next   = '0;
            data_offset_next = '0;
            data_length_next = '0;
            key_value_next   = '0;
            skey_next        = search_key;
            pos_next         = position;
            lo_next          = bclamp;
            // inverted range collapses to an empty one at begin
            if (eclamp < bclamp)
            begin
                n_next    = '0;
                epos_next = bclamp;
            end
            else
            begin
                n_next    = eclamp - bclamp;
                epos_next = eclamp;
            end
        end

        if (state_reg == pilu_pkg::ST_PROBE && n_reg == '0)
            found_pos_next = lo_reg;

        if (state_reg == pilu_pkg::ST_OFF2 && last_entry)
            data_length_next = total_length_reg - data_offset_reg;

        if (state_reg == pilu_pkg::ST_WAIT_B)
        begin
            case (kind_reg)
                pilu_pkg::FK_PROBE:
                begin
                    if (field < {1'b0, skey_reg})
                    begin
                        lo_next = mid + PW'(1);
                        n_next  = n_reg - half - PW'(1);
                    end
                    else
                    begin
                        n_next = half;
                    end
                end
                pilu_pkg::FK_CHECK: found_next = (field == {1'b0, skey_reg});
                pilu_pkg::FK_OFF1:  data_offset_next = field;
                pilu_pkg::FK_OFF2:  data_length_next = field - data_offset_reg;
                pilu_pkg::FK_KEY:   key_value_next = field[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pilu_pkg::ST_IDLE;
            kind_reg  <= pilu_pkg::FK_PROBE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg          <= lo_next;
        n_reg           <= n_next;
        epos_reg        <= epos_next;
        skey_reg        <= skey_next;
        pos_reg         <= pos_next;
        found_reg       <= found_next;
        found_pos_reg   <= found_pos_next;
        data_offset_reg <= data_offset_next;
        data_length_reg <= data_length_next;
        key_value_reg   <= key_value_next;
    end

    assign found       = found_reg;
    assign found_pos   = found_pos_reg;
    assign data_offset = data_offset_reg;
    assign data_length = data_length_reg;
    assign key_value   = key_value_reg;

endmodule
